@@ sv/hcbp_pkg.sv @@
package hcbp_pkg;

  localparam int SymbolCount = 256;
  localparam int MaxCodeLen  = 32;
  localparam int WordBits    = 32;
  localparam int LenLimit    = (MaxCodeLen < WordBits) ? MaxCodeLen : WordBits;
  localparam int TableDepth  = 256;
  localparam int AddrW       = 8;
  localparam int LenW        = 6;
  localparam int AccW        = 7 + LenLimit;
  localparam int CntW        = $clog2(AccW + 1);

  typedef enum logic [1:0] {
    OpLoad   = 2'd0,
    OpEncode = 2'd1,
    OpFlush  = 2'd2
  } op_e;

  typedef struct packed {
    logic                valid;
    logic                flush;
    logic [WordBits-1:0] code;
    logic [LenW-1:0]     len;
  } item_t;

  typedef struct packed {
    logic busy;
    logic take;
  } pk_stat_t;

endpackage

@@ sv/huffman_code_bit_packer.sv @@
// The first byte of an encode or flush passes the table read register, the accumulator
// and the output register. An encode or flush giving bytes holds the packer until its
// last whole byte is out; the packer emits one byte per cycle while out_stall_i is low.
// Loads write the table through its single write port.
// Reset clears the packer, the output valid flag and all table valid bits, so every
// symbol reads a zero length until loaded; the code words themselves are not cleared.
module huffman_code_bit_packer (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_stall_o,
  input  logic [1:0]  opcode_i,
  input  logic [7:0]  symbol_i,
  input  logic [31:0] code_word_i,
  input  logic [5:0]  code_length_i,
  output logic        out_valid_o,
  input  logic        out_stall_i,
  output logic [7:0]  out_byte_o,
  output logic        last_of_run_o
);

  logic                          accept;
  logic                          in_range;
  logic                          is_load;
  logic                          is_enc;
  logic                          is_flush;
  logic [hcbp_pkg::LenW-1:0]     len_sat;
  logic                          s0_valid_q, s0_valid_d;
  logic                          s0_flush_q;
  logic [hcbp_pkg::WordBits-1:0] rd_code;
  logic [hcbp_pkg::LenW-1:0]     rd_len;
  hcbp_pkg::item_t               item;
  hcbp_pkg::pk_stat_t            pk_stat;

  assign in_stall_o = s0_valid_q && pk_stat.busy;
  assign accept     = in_valid_i && !in_stall_o;
  assign in_range   = ({1'b0, symbol_i} < 9'(hcbp_pkg::SymbolCount));
  assign is_load    = (opcode_i == hcbp_pkg::OpLoad);
  assign is_enc     = (opcode_i == hcbp_pkg::OpEncode);
  assign is_flush   = (opcode_i == hcbp_pkg::OpFlush);
  assign len_sat    = (code_length_i > hcbp_pkg::LenW'(hcbp_pkg::LenLimit))
                    ? hcbp_pkg::LenW'(hcbp_pkg::LenLimit) : code_length_i;

  always_comb begin
    s0_valid_d = s0_valid_q;
    if (pk_stat.take) begin
      s0_valid_d = 1'b0;
    end
    if (accept) begin
      s0_valid_d = (is_enc && in_range) || is_flush;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_valid_q <= 1'b0;
    end else begin
      s0_valid_q <= s0_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_flush_q <= is_flush;
    end
  end

  hcbp_table u_table (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (accept && is_load && in_range),
    .wr_addr_i (symbol_i),
    .wr_code_i (code_word_i),
    .wr_len_i  (len_sat),
    .rd_en_i   (accept),
    .rd_addr_i (symbol_i),
    .rd_code_o (rd_code),
    .rd_len_o  (rd_len)
  );

  assign item.valid = s0_valid_q;
  assign item.flush = s0_flush_q;
  assign item.code  = rd_code;
  assign item.len   = rd_len;

  hcbp_packer u_packer (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .item_i        (item),
    .stat_o        (pk_stat),
    .out_valid_o   (out_valid_o),
    .out_stall_i   (out_stall_i),
    .out_byte_o    (out_byte_o),
    .last_of_run_o (last_of_run_o)
  );

  a_run_continues : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !last_of_run_o |=> out_valid_o)
    else $error("byte run ended without a last marker");

  a_stall_only_when_busy : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_stall_o |-> s0_valid_q && pk_stat.busy)
    else $error("input stalled while the packer could take the held item");

  a_out_held_while_stalled : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=>
      out_valid_o && $stable(out_byte_o) && $stable(last_of_run_o))
    else $error("stalled output byte changed");

endmodule

@@ sv/hcbp_table.sv @@
module hcbp_table (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           wr_en_i,
  input  logic [hcbp_pkg::AddrW-1:0]     wr_addr_i,
  input  logic [hcbp_pkg::WordBits-1:0]  wr_code_i,
  input  logic [hcbp_pkg::LenW-1:0]      wr_len_i,
  input  logic                           rd_en_i,
  input  logic [hcbp_pkg::AddrW-1:0]     rd_addr_i,
  output logic [hcbp_pkg::WordBits-1:0]  rd_code_o,
  output logic [hcbp_pkg::LenW-1:0]      rd_len_o
);

  localparam int EntW = hcbp_pkg::WordBits + hcbp_pkg::LenW;

  logic [EntW-1:0]                  mem [hcbp_pkg::TableDepth];
  logic [hcbp_pkg::TableDepth-1:0]  vld_q;
  logic [EntW-1:0]                  rd_q;
  logic                             rd_vld_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= {wr_len_i, wr_code_i};
    end
    if (rd_en_i) begin
      rd_q <= mem[rd_addr_i];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      rd_vld_q <= 1'b0;
    end else begin
      if (wr_en_i) begin
        vld_q[wr_addr_i] <= 1'b1;
      end
      if (rd_en_i) begin
        rd_vld_q <= vld_q[rd_addr_i];
      end
    end
  end

  assign rd_code_o = rd_q[hcbp_pkg::WordBits-1:0];
  assign rd_len_o  = rd_vld_q ? rd_q[EntW-1:hcbp_pkg::WordBits] : '0;

endmodule

@@ sv/hcbp_packer.sv @@
module hcbp_packer (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  hcbp_pkg::item_t    item_i,
  output hcbp_pkg::pk_stat_t stat_o,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [7:0]         out_byte_o,
  output logic               last_of_run_o
);

  logic [hcbp_pkg::AccW-1:0]     acc_q, acc_d;
  logic [hcbp_pkg::CntW-1:0]     cnt_q, cnt_d;
  logic                          out_valid_q, out_valid_d;
  logic [7:0]                    out_byte_q, out_byte_d;
  logic                          last_q, last_d;
  logic                          busy;
  logic                          take;
  logic                          out_ready;
  logic [6:0]                    pend;
  logic [hcbp_pkg::WordBits:0]   cmask;
  logic [hcbp_pkg::CntW-1:0]     emit_sh;

  assign busy      = (cnt_q >= hcbp_pkg::CntW'(8));
  assign take      = item_i.valid && !busy;
  assign out_ready = !out_valid_q || !out_stall_i;
  assign pend      = acc_q[6:0] & ((7'd1 << cnt_q[2:0]) - 7'd1);
  assign cmask     = ((hcbp_pkg::WordBits + 1)'(1) << item_i.len) - (hcbp_pkg::WordBits + 1)'(1);
  assign emit_sh   = cnt_q - hcbp_pkg::CntW'(8);

  always_comb begin
    acc_d       = acc_q;
    cnt_d       = cnt_q;
    out_valid_d = out_valid_q;
    out_byte_d  = out_byte_q;
    last_d      = last_q;
    if (out_ready) begin
      out_valid_d = 1'b0;
    end
    if (busy) begin
      if (out_ready) begin
        out_valid_d = 1'b1;
        out_byte_d  = 8'(acc_q >> emit_sh);
        last_d      = (cnt_q < hcbp_pkg::CntW'(16));
        cnt_d       = emit_sh;
      end
    end else if (take) begin
      if (item_i.flush) begin
        if (cnt_q[2:0] != 3'd0) begin
          acc_d = hcbp_pkg::AccW'(8'({1'b0, pend} << (4'd8 - {1'b0, cnt_q[2:0]})));
          cnt_d = hcbp_pkg::CntW'(8);
        end
      end else begin
        acc_d = (hcbp_pkg::AccW'(pend) << item_i.len)
              | hcbp_pkg::AccW'(item_i.code & cmask[hcbp_pkg::WordBits-1:0]);
        cnt_d = hcbp_pkg::CntW'(cnt_q[2:0]) + hcbp_pkg::CntW'(item_i.len);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      acc_q       <= '0;
      cnt_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      acc_q       <= acc_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_byte_q <= out_byte_d;
    last_q     <= last_d;
  end

  assign stat_o.busy   = busy;
  assign stat_o.take   = take;
  assign out_valid_o   = out_valid_q;
  assign out_byte_o    = out_byte_q;
  assign last_of_run_o = last_q;

endmodule
